>>> rtl/core/two_level_inclusive_lru_cache_core_macros.svh
// Assertion macros shared by the cache core modules.
// Used by tilru_dp and tilru_ctrl; expects clk and arst_n in scope.
`ifndef TWO_LEVEL_INCLUSIVE_LRU_CACHE_CORE_MACROS_SVH
`define TWO_LEVEL_INCLUSIVE_LRU_CACHE_CORE_MACROS_SVH

// same-cycle implication
`define TILRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TILRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tilru_pkg.sv
// Shared types and constants of the two-level cache core.
// No dependencies; used by every module of the core but tilru_set_mem.
package tilru_pkg;

	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int WB_W       = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_OFFSET = 3'd0,
		CFG_L1_SETS      = 3'd1,
		CFG_L1_WAYS      = 3'd2,
		CFG_L2_SETS      = 3'd3,
		CFG_L2_WAYS      = 3'd4,
		CFG_WRITE_ALLOC  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_L1_HIT = 2'd0,
		OUT_L2_HIT = 2'd1,
		OUT_MISS   = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ROW_HIT  = 2'd0,
		ROW_FILL = 2'd1,
		ROW_DROP = 2'd2
	} row_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_LK, S_DRRD, S_DRWR, S_F1RD, S_F1WR, S_VDRD, S_VDWR, S_OUT
	} state_t;

	typedef struct packed {
		logic [3:0] block_offset_bits;
		logic [2:0] l1_set_bits;
		logic [1:0] l1_way_bits;
		logic [3:0] l2_set_bits;
		logic [1:0] l2_way_bits;
		logic       write_allocate;
	} cfg_t;

	typedef struct packed {
		logic    capture;
		logic    l1_rd;
		logic    l1_wr;
		logic    l1_key_victim;
		row_op_t l1_op;
		logic    l1_dirty;
		logic    l2_rd;
		logic    l2_wr;
		logic    l2_key_victim;
		row_op_t l2_op;
		logic    l2_dirty;
		logic    count;
		logic    cap_l2_victim;
		logic    cap_l1_victim;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic wr;
		logic walloc;
		logic l1_hit;
		logic l2_hit;
		logic l2_evict;
		logic l1_evict_dirty;
		logic out_busy;
	} dp_status_t;

endpackage

>>> rtl/core/two_level_inclusive_lru_cache_core.sv
// Top level of the two-level inclusive write-back LRU tag store.
// Depends on tilru_pkg, tilru_dp and tilru_ctrl.
//
// Usage:
//  - cfg channel: write cfg_data to register cfg_index (0 block offset bits,
//    1 L1 set bits, 2 L1 way bits, 3 L2 set bits, 4 L2 way bits,
//    5 write allocate); always ready. Write only while no access is in flight.
//  - s_axis: one word per access, tdata = byte address, tuser = write flag.
//  - m_axis: one word per access, tuser = outcome (L1 hit, L2 hit, miss),
//    tdata = L1 accesses, L1 misses, L2 accesses, L2 misses after the access.
//  - After the lookup, an L1 hit or a write without allocate goes straight
//    to the result; else an L2 eviction first back-invalidates L1, then L1
//    is filled, and a dirty L1 victim is then marked in L2. Each step is a
//    read then a write of one set row, and one access is sequenced at a
//    time: the next word is taken in the cycle after the result loads.
//  - The result sits in an output register; a new word is taken while it
//    waits. A stalled receiver holds the sequencer at its result step.
//  - Reset clears counters, row-valid flops (so every set reads as empty
//    with rank equal to way) and loads the default geometry at once.
module two_level_inclusive_lru_cache_core #(
	parameter int L1_MAX_SETS = 64,
	parameter int L1_MAX_WAYS = 4,
	parameter int L2_MAX_SETS = 256,
	parameter int L2_MAX_WAYS = 8,
	parameter int ADDR_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tilru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tilru_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [ADDR_BITS-1:0] address, zero padded to whole bytes
	input  logic [((ADDR_BITS+7)/8)*8-1:0]       s_axis_tdata,
	// [0] operation (1 = write)
	input  logic [0:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [31:0] l1_accesses, [63:32] l1_misses, [95:64] l2_accesses, [127:96] l2_misses
	output logic [4*tilru_pkg::CNT_W-1:0]        m_axis_tdata,
	// [1:0] outcome
	output logic [1:0]                           m_axis_tuser
);
	localparam int CW = tilru_pkg::CNT_W;

	tilru_pkg::cfg_t       cfg_q;
	tilru_pkg::dp_cmd_t    cmd;
	tilru_pkg::dp_status_t status;
	tilru_pkg::outcome_t   outcome;
	logic [CW-1:0]         l1_acc, l1_miss, l2_acc, l2_miss;

	assign cfg_ready = 1'b1;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_offset_bits <= 4'd2;
			cfg_q.l1_set_bits       <= 3'd4;
			cfg_q.l1_way_bits       <= 2'd1;
			cfg_q.l2_set_bits       <= 4'd6;
			cfg_q.l2_way_bits       <= 2'd2;
			cfg_q.write_allocate    <= 1'b1;
		end else if (cfg_valid) begin
			case (tilru_pkg::cfg_reg_t'(cfg_index))
				tilru_pkg::CFG_BLOCK_OFFSET: cfg_q.block_offset_bits <= cfg_data;
				tilru_pkg::CFG_L1_SETS:      cfg_q.l1_set_bits       <= cfg_data[2:0];
				tilru_pkg::CFG_L1_WAYS:      cfg_q.l1_way_bits       <= cfg_data[1:0];
				tilru_pkg::CFG_L2_SETS:      cfg_q.l2_set_bits       <= cfg_data;
				tilru_pkg::CFG_L2_WAYS:      cfg_q.l2_way_bits       <= cfg_data[1:0];
				tilru_pkg::CFG_WRITE_ALLOC:  cfg_q.write_allocate    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tilru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tilru_dp #(
		.L1_MAX_SETS (L1_MAX_SETS),
		.L1_MAX_WAYS (L1_MAX_WAYS),
		.L2_MAX_SETS (L2_MAX_SETS),
		.L2_MAX_WAYS (L2_MAX_WAYS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_wr       (s_axis_tuser[0]),
		.in_addr     (s_axis_tdata[ADDR_BITS-1:0]),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_outcome (outcome),
		.out_l1_acc  (l1_acc),
		.out_l1_miss (l1_miss),
		.out_l2_acc  (l2_acc),
		.out_l2_miss (l2_miss)
	);

	assign m_axis_tuser = outcome;
	assign m_axis_tdata = {l2_miss, l2_acc, l1_miss, l1_acc};

endmodule

>>> rtl/core/tilru_set_mem.sv
// One cache level's set memory: one row holds every way of a set.
// Depends on nothing but the clock; row-valid flops give reset contents.
module tilru_set_mem #(
	parameter int SW   = 6,
	parameter int WAYS = 4,
	parameter int RW   = 2,
	parameter int TW   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [SW-1:0]               rd_idx,
	input  logic                        wr_en,
	input  logic [SW-1:0]               wr_idx,
	input  logic [WAYS*(TW+2+RW)-1:0]   wr_row,
	output logic [WAYS*(TW+2+RW)-1:0]   rd_row
);
	localparam int ROW_W = WAYS * (TW + 2 + RW);
	localparam int DEPTH = 2 ** SW;

	logic [ROW_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] row_vld_q;
	logic [ROW_W-1:0] rd_data_q;
	logic             rd_vld_q;
	logic [ROW_W-1:0] reset_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_idx];
			end
		end
	end

	// untouched set: nothing valid, rank equals way index
	always_comb begin
		reset_row = '0;
		for (int w = 0; w < WAYS; w++) begin
			reset_row[w*RW +: RW] = RW'(w);
		end
	end

	assign rd_row = rd_vld_q ? rd_data_q : reset_row;

endmodule

>>> rtl/core/tilru_row_ops.sv
// Lookup, fill, drop and LRU rank update on one set row.
// Depends on tilru_pkg for the row operation codes.
module tilru_row_ops #(
	parameter int WAYS = 4,
	parameter int RW   = 2,
	parameter int TW   = 32
) (
	input  logic [WAYS*TW-1:0]         tag_i,
	input  logic [WAYS-1:0]            valid_i,
	input  logic [WAYS-1:0]            dirty_i,
	input  logic [WAYS*RW-1:0]         rank_i,
	input  logic [TW-1:0]              key,
	input  logic [tilru_pkg::WB_W-1:0] wbits,
	input  tilru_pkg::row_op_t         op,
	input  logic                       set_dirty,
	output logic [WAYS*TW-1:0]         tag_o,
	output logic [WAYS-1:0]            valid_o,
	output logic [WAYS-1:0]            dirty_o,
	output logic [WAYS*RW-1:0]         rank_o,
	output logic                       hit,
	output logic                       evicted,
	output logic [TW-1:0]              vtag,
	output logic                       vdirty
);
	always_comb begin
		int          nw;
		int          hway;
		int          fway;
		int          tway;
		logic        found;
		logic        free_found;
		logic        do_touch;
		logic [RW-1:0] old_rank;
		logic [RW-1:0] top_rank;

		nw       = 1 << wbits;
		top_rank = RW'(nw - 1);
		found    = 1'b0;
		hway     = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (w < nw && !found && valid_i[w] && tag_i[w*TW +: TW] == key) begin
				found = 1'b1;
				hway  = w;
			end
		end

		// first free way, else the last way at rank zero
		free_found = 1'b0;
		fway       = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (w < nw && !free_found && !valid_i[w]) begin
				free_found = 1'b1;
				fway       = w;
			end
		end
		if (!free_found) begin
			for (int w = 0; w < WAYS; w++) begin
				if (w < nw && rank_i[w*RW +: RW] == '0) begin
					fway = w;
				end
			end
		end

		hit     = found;
		evicted = !free_found;
		vtag    = tag_i[fway*TW +: TW];
		vdirty  = dirty_i[fway];

		tag_o    = tag_i;
		valid_o  = valid_i;
		dirty_o  = dirty_i;
		rank_o   = rank_i;
		do_touch = 1'b0;
		tway     = hway;
		case (op)
			tilru_pkg::ROW_HIT: begin
				if (found) begin
					dirty_o[hway] = dirty_i[hway] | set_dirty;
					do_touch      = 1'b1;
				end
			end
			tilru_pkg::ROW_FILL: begin
				tway                  = fway;
				valid_o[fway]         = 1'b1;
				dirty_o[fway]         = set_dirty;
				tag_o[fway*TW +: TW]  = key;
				do_touch              = 1'b1;
			end
			tilru_pkg::ROW_DROP: begin
				if (found) begin
					valid_o[hway] = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// touched way becomes most recent, younger ones age by one
		old_rank = rank_i[tway*RW +: RW];
		if (do_touch) begin
			for (int w = 0; w < WAYS; w++) begin
				if (w < nw && w != tway && rank_i[w*RW +: RW] > old_rank) begin
					rank_o[w*RW +: RW] = rank_i[w*RW +: RW] - RW'(1);
				end
			end
			rank_o[tway*RW +: RW] = top_rank;
		end
	end

endmodule

>>> rtl/core/tilru_dp.sv
// Datapath: both set memories, row logic, key and victim registers, counters.
// Depends on tilru_pkg, tilru_set_mem, tilru_row_ops and the macro header.
`include "two_level_inclusive_lru_cache_core_macros.svh"

module tilru_dp #(
	parameter int L1_MAX_SETS = 64,
	parameter int L1_MAX_WAYS = 4,
	parameter int L2_MAX_SETS = 256,
	parameter int L2_MAX_WAYS = 8,
	parameter int ADDR_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tilru_pkg::cfg_t               cfg,
	input  logic                          in_wr,
	input  logic [ADDR_BITS-1:0]          in_addr,
	input  tilru_pkg::dp_cmd_t            cmd,
	output tilru_pkg::dp_status_t         status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output tilru_pkg::outcome_t           out_outcome,
	output logic [tilru_pkg::CNT_W-1:0]   out_l1_acc,
	output logic [tilru_pkg::CNT_W-1:0]   out_l1_miss,
	output logic [tilru_pkg::CNT_W-1:0]   out_l2_acc,
	output logic [tilru_pkg::CNT_W-1:0]   out_l2_miss
);
	localparam int L1_SLOG = $clog2(L1_MAX_SETS + 1) - 1;
	localparam int L1_SW   = (L1_SLOG < 1) ? 1 : L1_SLOG;
	localparam int L1_WLOG = $clog2(L1_MAX_WAYS + 1) - 1;
	localparam int L1_RW   = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
	localparam int L2_SLOG = $clog2(L2_MAX_SETS + 1) - 1;
	localparam int L2_SW   = (L2_SLOG < 1) ? 1 : L2_SLOG;
	localparam int L2_WLOG = $clog2(L2_MAX_WAYS + 1) - 1;
	localparam int L2_RW   = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
	localparam int TW      = ADDR_BITS;
	localparam int L1_ROW  = L1_MAX_WAYS * (TW + 2 + L1_RW);
	localparam int L2_ROW  = L2_MAX_WAYS * (TW + 2 + L2_RW);
	localparam int CW      = tilru_pkg::CNT_W;

	logic                wr_q;
	logic [TW-1:0]       blk_q;
	logic [TW-1:0]       v1_q;
	logic [TW-1:0]       v2_q;
	logic [L1_SW-1:0]    l1_idx_q;
	logic [L2_SW-1:0]    l2_idx_q;
	logic [CW-1:0]       l1_acc_q, l1_miss_q, l2_acc_q, l2_miss_q;
	logic                out_valid_q;
	tilru_pkg::outcome_t outcome_q;
	tilru_pkg::outcome_t o_outcome_q;
	logic [CW-1:0]       o_l1_acc_q, o_l1_miss_q, o_l2_acc_q, o_l2_miss_q;

	logic [4:0]                 l1_sb, l2_sb;
	logic [tilru_pkg::WB_W-1:0] l1_wb, l2_wb;
	logic [L1_SW-1:0]           l1_mask, l1_set;
	logic [L2_SW-1:0]           l2_mask, l2_set;
	logic [TW-1:0]              l1_key, l2_key;

	logic [L1_ROW-1:0] l1_rd_row, l1_wr_row;
	logic [L2_ROW-1:0] l2_rd_row, l2_wr_row;

	logic                        l1_hit, l1_evicted, l1_vdirty;
	logic [TW-1:0]               l1_vtag;
	logic                        l2_hit, l2_evicted, l2_vdirty;
	logic [TW-1:0]               l2_vtag;
	logic [L1_MAX_WAYS*TW-1:0]   l1_tag_o;
	logic [L1_MAX_WAYS-1:0]      l1_valid_o, l1_dirty_o;
	logic [L1_MAX_WAYS*L1_RW-1:0] l1_rank_o;
	logic [L2_MAX_WAYS*TW-1:0]   l2_tag_o;
	logic [L2_MAX_WAYS-1:0]      l2_valid_o, l2_dirty_o;
	logic [L2_MAX_WAYS*L2_RW-1:0] l2_rank_o;

	// geometry saturates at what the memories hold
	assign l1_sb = (int'(cfg.l1_set_bits) > L1_SLOG) ? 5'(L1_SLOG) : 5'(cfg.l1_set_bits);
	assign l2_sb = (int'(cfg.l2_set_bits) > L2_SLOG) ? 5'(L2_SLOG) : 5'(cfg.l2_set_bits);
	assign l1_wb = (int'(cfg.l1_way_bits) > L1_WLOG) ? tilru_pkg::WB_W'(L1_WLOG)
		: tilru_pkg::WB_W'(cfg.l1_way_bits);
	assign l2_wb = (int'(cfg.l2_way_bits) > L2_WLOG) ? tilru_pkg::WB_W'(L2_WLOG)
		: tilru_pkg::WB_W'(cfg.l2_way_bits);
	assign l1_mask = L1_SW'((32'd1 << l1_sb) - 32'd1);
	assign l2_mask = L2_SW'((32'd1 << l2_sb) - 32'd1);

	assign l1_key = cmd.l1_key_victim ? v2_q : blk_q;
	assign l2_key = cmd.l2_key_victim ? v1_q : blk_q;
	assign l1_set = L1_SW'(l1_key) & l1_mask;
	assign l2_set = L2_SW'(l2_key) & l2_mask;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wr_q  <= in_wr;
			blk_q <= in_addr >> cfg.block_offset_bits;
		end
		if (cmd.l1_rd) begin
			l1_idx_q <= l1_set;
		end
		if (cmd.l2_rd) begin
			l2_idx_q <= l2_set;
		end
		if (cmd.cap_l2_victim) begin
			v2_q <= l2_vtag;
		end
		if (cmd.cap_l1_victim) begin
			v1_q <= l1_vtag;
		end
		if (cmd.load_out) begin
			o_outcome_q <= outcome_q;
			o_l1_acc_q  <= l1_acc_q;
			o_l1_miss_q <= l1_miss_q;
			o_l2_acc_q  <= l2_acc_q;
			o_l2_miss_q <= l2_miss_q;
		end
	end

	tilru_set_mem #(.SW(L1_SW), .WAYS(L1_MAX_WAYS), .RW(L1_RW), .TW(TW)) u_l1_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (cmd.l1_rd),
		.rd_idx (l1_set),
		.wr_en  (cmd.l1_wr),
		.wr_idx (l1_idx_q),
		.wr_row (l1_wr_row),
		.rd_row (l1_rd_row)
	);

	tilru_set_mem #(.SW(L2_SW), .WAYS(L2_MAX_WAYS), .RW(L2_RW), .TW(TW)) u_l2_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (cmd.l2_rd),
		.rd_idx (l2_set),
		.wr_en  (cmd.l2_wr),
		.wr_idx (l2_idx_q),
		.wr_row (l2_wr_row),
		.rd_row (l2_rd_row)
	);

	// row layout from the top: tags, valid, dirty, ranks
	tilru_row_ops #(.WAYS(L1_MAX_WAYS), .RW(L1_RW), .TW(TW)) u_l1_ops (
		.tag_i     (l1_rd_row[L1_ROW-1 -: L1_MAX_WAYS*TW]),
		.valid_i   (l1_rd_row[L1_MAX_WAYS*(L1_RW+2)-1 -: L1_MAX_WAYS]),
		.dirty_i   (l1_rd_row[L1_MAX_WAYS*(L1_RW+1)-1 -: L1_MAX_WAYS]),
		.rank_i    (l1_rd_row[L1_MAX_WAYS*L1_RW-1:0]),
		.key       (l1_key),
		.wbits     (l1_wb),
		.op        (cmd.l1_op),
		.set_dirty (cmd.l1_dirty),
		.tag_o     (l1_tag_o),
		.valid_o   (l1_valid_o),
		.dirty_o   (l1_dirty_o),
		.rank_o    (l1_rank_o),
		.hit       (l1_hit),
		.evicted   (l1_evicted),
		.vtag      (l1_vtag),
		.vdirty    (l1_vdirty)
	);

	tilru_row_ops #(.WAYS(L2_MAX_WAYS), .RW(L2_RW), .TW(TW)) u_l2_ops (
		.tag_i     (l2_rd_row[L2_ROW-1 -: L2_MAX_WAYS*TW]),
		.valid_i   (l2_rd_row[L2_MAX_WAYS*(L2_RW+2)-1 -: L2_MAX_WAYS]),
		.dirty_i   (l2_rd_row[L2_MAX_WAYS*(L2_RW+1)-1 -: L2_MAX_WAYS]),
		.rank_i    (l2_rd_row[L2_MAX_WAYS*L2_RW-1:0]),
		.key       (l2_key),
		.wbits     (l2_wb),
		.op        (cmd.l2_op),
		.set_dirty (cmd.l2_dirty),
		.tag_o     (l2_tag_o),
		.valid_o   (l2_valid_o),
		.dirty_o   (l2_dirty_o),
		.rank_o    (l2_rank_o),
		.hit       (l2_hit),
		.evicted   (l2_evicted),
		.vtag      (l2_vtag),
		.vdirty    (l2_vdirty)
	);

	assign l1_wr_row = {l1_tag_o, l1_valid_o, l1_dirty_o, l1_rank_o};
	assign l2_wr_row = {l2_tag_o, l2_valid_o, l2_dirty_o, l2_rank_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_acc_q    <= '0;
			l1_miss_q   <= '0;
			l2_acc_q    <= '0;
			l2_miss_q   <= '0;
			out_valid_q <= 1'b0;
			outcome_q   <= tilru_pkg::OUT_L1_HIT;
		end else begin
			if (cmd.count) begin
				l1_acc_q <= l1_acc_q + CW'(1);
				if (l1_hit) begin
					outcome_q <= tilru_pkg::OUT_L1_HIT;
				end else begin
					l1_miss_q <= l1_miss_q + CW'(1);
					l2_acc_q  <= l2_acc_q + CW'(1);
					if (l2_hit) begin
						outcome_q <= tilru_pkg::OUT_L2_HIT;
					end else begin
						outcome_q <= tilru_pkg::OUT_MISS;
						l2_miss_q <= l2_miss_q + CW'(1);
					end
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.wr             = wr_q;
	assign status.walloc         = cfg.write_allocate;
	assign status.l1_hit         = l1_hit;
	assign status.l2_hit         = l2_hit;
	assign status.l2_evict       = l2_evicted;
	assign status.l1_evict_dirty = l1_evicted & l1_vdirty;
	assign status.out_busy       = out_valid_q & ~out_ready;

	assign out_valid   = out_valid_q;
	assign out_outcome = o_outcome_q;
	assign out_l1_acc  = o_l1_acc_q;
	assign out_l1_miss = o_l1_miss_q;
	assign out_l2_acc  = o_l2_acc_q;
	assign out_l2_miss = o_l2_miss_q;

	`TILRU_ASSERT_NOW(a_l2_acc_eq_l1_miss, 1'b1, l2_acc_q == l1_miss_q,
		"L2 access count drifted from L1 miss count")
	`TILRU_ASSERT_NEXT(a_acc_step, cmd.count, l1_acc_q == $past(l1_acc_q) + CW'(1),
		"access count did not advance by one")

endmodule

>>> rtl/core/tilru_ctrl.sv
// Sequencer of one access: lookup, L2 update, back-invalidate, L1 fill, write-back mark.
// Depends on tilru_pkg and the macro header.
`include "two_level_inclusive_lru_cache_core_macros.svh"

module tilru_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tilru_pkg::dp_status_t status,
	output tilru_pkg::dp_cmd_t    cmd
);
	tilru_pkg::state_t state_q, state_nx;
	logic              do_alloc;

	assign do_alloc = ~status.wr | status.walloc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tilru_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tilru_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = tilru_pkg::S_RD;
				end
			end
			tilru_pkg::S_RD: state_nx = tilru_pkg::S_LK;
			tilru_pkg::S_LK: begin
				if (status.l1_hit || !do_alloc) begin
					state_nx = tilru_pkg::S_OUT;
				end else if (!status.l2_hit && status.l2_evict) begin
					state_nx = tilru_pkg::S_DRRD;
				end else begin
					state_nx = tilru_pkg::S_F1RD;
				end
			end
			tilru_pkg::S_DRRD: state_nx = tilru_pkg::S_DRWR;
			tilru_pkg::S_DRWR: state_nx = tilru_pkg::S_F1RD;
			tilru_pkg::S_F1RD: state_nx = tilru_pkg::S_F1WR;
			tilru_pkg::S_F1WR: begin
				state_nx = status.l1_evict_dirty ? tilru_pkg::S_VDRD : tilru_pkg::S_OUT;
			end
			tilru_pkg::S_VDRD: state_nx = tilru_pkg::S_VDWR;
			tilru_pkg::S_VDWR: state_nx = tilru_pkg::S_OUT;
			tilru_pkg::S_OUT: begin
				if (!status.out_busy) begin
					state_nx = tilru_pkg::S_IDLE;
				end
			end
			default: state_nx = tilru_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.l1_op = tilru_pkg::ROW_HIT;
		cmd.l2_op = tilru_pkg::ROW_HIT;
		in_ready = 1'b0;
		case (state_q)
			tilru_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			tilru_pkg::S_RD: begin
				cmd.l1_rd = 1'b1;
				cmd.l2_rd = 1'b1;
			end
			tilru_pkg::S_LK: begin
				cmd.count         = 1'b1;
				cmd.l1_dirty      = status.wr;
				cmd.cap_l2_victim = 1'b1;
				if (status.l1_hit) begin
					cmd.l1_wr = 1'b1;
				end else if (status.l2_hit) begin
					cmd.l2_wr    = 1'b1;
					cmd.l2_dirty = ~do_alloc;
				end else begin
					cmd.l2_wr = do_alloc;
					cmd.l2_op = tilru_pkg::ROW_FILL;
				end
			end
			tilru_pkg::S_DRRD: begin
				cmd.l1_rd         = 1'b1;
				cmd.l1_key_victim = 1'b1;
			end
			tilru_pkg::S_DRWR: begin
				cmd.l1_wr         = 1'b1;
				cmd.l1_key_victim = 1'b1;
				cmd.l1_op         = tilru_pkg::ROW_DROP;
			end
			tilru_pkg::S_F1RD: cmd.l1_rd = 1'b1;
			tilru_pkg::S_F1WR: begin
				cmd.l1_wr         = 1'b1;
				cmd.l1_op         = tilru_pkg::ROW_FILL;
				cmd.l1_dirty      = status.wr;
				cmd.cap_l1_victim = 1'b1;
			end
			tilru_pkg::S_VDRD: begin
				cmd.l2_rd         = 1'b1;
				cmd.l2_key_victim = 1'b1;
			end
			tilru_pkg::S_VDWR: begin
				cmd.l2_wr         = 1'b1;
				cmd.l2_key_victim = 1'b1;
				cmd.l2_dirty      = 1'b1;
			end
			tilru_pkg::S_OUT: cmd.load_out = ~status.out_busy;
			default: begin
			end
		endcase
	end

	`TILRU_ASSERT_NEXT(a_l1_hit_done, state_q == tilru_pkg::S_LK && status.l1_hit,
		state_q == tilru_pkg::S_OUT, "L1 hit did not go straight to result")
	`TILRU_ASSERT_NEXT(a_load_idle, cmd.load_out, state_q == tilru_pkg::S_IDLE,
		"result load did not return to idle")

endmodule
